// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with async active-low reset as disable.
`define CLRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent must be followed, in the same cycle, by the consequent.
`define CLRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`CLRQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: rtl/core/clrq_pkg.sv
// ----------------------------------------------------------------------------
// clrq_pkg
// Shared opcodes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package clrq_pkg;

	// request opcodes
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_ROTATE  = 2'd1;
	localparam logic [1:0] OP_EXTRACT = 2'd2;
	localparam logic [1:0] OP_LENGTH  = 2'd3;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// link read address select
	localparam logic [1:0] LRD_FREE   = 2'd0;
	localparam logic [1:0] LRD_CURSOR = 2'd1;
	localparam logic [1:0] LRD_RDATA  = 2'd2;

	// link write select: {address, data}
	localparam logic [2:0] LWR_SELF        = 3'd0; // link[slot]   = slot
	localparam logic [2:0] LWR_SLOT_NEXT   = 3'd1; // link[slot]   = rdata
	localparam logic [2:0] LWR_CURSOR_SLOT = 3'd2; // link[cursor] = slot
	localparam logic [2:0] LWR_CURSOR_NEXT = 3'd3; // link[cursor] = rdata
	localparam logic [2:0] LWR_VICTIM_FREE = 3'd4; // link[victim] = free head

	typedef struct packed {
		logic       latch;
		logic       take_free;
		logic       take_fresh;
		logic       free_from_rd;
		logic       link_rd_en;
		logic [1:0] link_rd_sel;
		logic       link_wr_en;
		logic [2:0] link_wr_sel;
		logic       pay_wr_en;
		logic       pay_rd_en;
		logic       cursor_to_slot;
		logic       cursor_from_rd;
		logic       live_inc;
		logic       live_dec;
		logic       victim_ld;
		logic       give_victim;
		logic       result_ld;
		logic       steps_dec;
		logic       resp_en;
		logic [1:0] resp_status;
	} clrq_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       reuse;
		logic       multi;
		logic       steps_zero;
		logic       steps_one;
	} clrq_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/clrq_ram.sv
// ----------------------------------------------------------------------------
// clrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/clrq_ctrl.sv
// ----------------------------------------------------------------------------
// clrq_ctrl
// Request sequencer: walks each opcode through its memory read/write steps.
// ----------------------------------------------------------------------------
`default_nettype none

module clrq_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire clrq_pkg::clrq_stat_t  stat,
	output logic                       busy,
	output clrq_pkg::clrq_cmd_t        cmd
);

	import clrq_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_INS1 = 4'd2;
	localparam logic [3:0] S_INS2 = 4'd3;
	localparam logic [3:0] S_INS3 = 4'd4;
	localparam logic [3:0] S_INS4 = 4'd5;
	localparam logic [3:0] S_ROT  = 4'd6;
	localparam logic [3:0] S_EXT1 = 4'd7;
	localparam logic [3:0] S_EXT2 = 4'd8;
	localparam logic [3:0] S_EXT3 = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.resp_en     = 1'b1;
							cmd.resp_status = ST_FULL;
							state_d         = S_IDLE;
						end else if (stat.reuse) begin
							// recycle a freed slot: fetch its free-chain link
							cmd.take_free   = 1'b1;
							cmd.link_rd_en  = 1'b1;
							cmd.link_rd_sel = LRD_FREE;
							state_d         = S_INS1;
						end else begin
							cmd.take_fresh = 1'b1;
							state_d        = S_INS2;
						end
					end
					OP_ROTATE: begin
						if (stat.empty) begin
							cmd.resp_en     = 1'b1;
							cmd.resp_status = ST_EMPTY;
							state_d         = S_IDLE;
						end else if (stat.steps_zero) begin
							cmd.resp_en     = 1'b1;
							cmd.resp_status = ST_OK;
							state_d         = S_IDLE;
						end else begin
							cmd.link_rd_en  = 1'b1;
							cmd.link_rd_sel = LRD_CURSOR;
							state_d         = S_ROT;
						end
					end
					OP_EXTRACT: begin
						if (stat.empty) begin
							cmd.resp_en     = 1'b1;
							cmd.resp_status = ST_EMPTY;
							state_d         = S_IDLE;
						end else begin
							cmd.link_rd_en  = 1'b1;
							cmd.link_rd_sel = LRD_CURSOR;
							state_d         = S_EXT1;
						end
					end
					OP_LENGTH: begin
						cmd.resp_en     = 1'b1;
						cmd.resp_status = ST_OK;
						state_d         = S_IDLE;
					end
				endcase
			end
			S_INS1: begin
				cmd.free_from_rd = 1'b1;
				state_d          = S_INS2;
			end
			S_INS2: begin
				cmd.pay_wr_en = 1'b1;
				if (stat.empty) begin
					// first entry links to itself
					cmd.link_wr_en     = 1'b1;
					cmd.link_wr_sel    = LWR_SELF;
					cmd.cursor_to_slot = 1'b1;
					cmd.live_inc       = 1'b1;
					cmd.resp_en        = 1'b1;
					cmd.resp_status    = ST_OK;
					state_d            = S_IDLE;
				end else begin
					cmd.link_rd_en  = 1'b1;
					cmd.link_rd_sel = LRD_CURSOR;
					state_d         = S_INS3;
				end
			end
			S_INS3: begin
				cmd.link_wr_en  = 1'b1;
				cmd.link_wr_sel = LWR_SLOT_NEXT;
				state_d         = S_INS4;
			end
			S_INS4: begin
				cmd.link_wr_en     = 1'b1;
				cmd.link_wr_sel    = LWR_CURSOR_SLOT;
				cmd.cursor_to_slot = 1'b1;
				cmd.live_inc       = 1'b1;
				cmd.resp_en        = 1'b1;
				cmd.resp_status    = ST_OK;
				state_d            = S_IDLE;
			end
			S_ROT: begin
				cmd.cursor_from_rd = 1'b1;
				cmd.steps_dec      = 1'b1;
				if (stat.steps_one) begin
					cmd.resp_en     = 1'b1;
					cmd.resp_status = ST_OK;
					state_d         = S_IDLE;
				end else begin
					cmd.link_rd_en  = 1'b1;
					cmd.link_rd_sel = LRD_RDATA;
				end
			end
			S_EXT1: begin
				// rdata is the victim; fetch its link and payload
				cmd.victim_ld   = 1'b1;
				cmd.link_rd_en  = 1'b1;
				cmd.link_rd_sel = LRD_RDATA;
				cmd.pay_rd_en   = 1'b1;
				state_d         = S_EXT2;
			end
			S_EXT2: begin
				cmd.result_ld = 1'b1;
				if (stat.multi) begin
					cmd.link_wr_en  = 1'b1;
					cmd.link_wr_sel = LWR_CURSOR_NEXT;
				end
				state_d = S_EXT3;
			end
			S_EXT3: begin
				cmd.link_wr_en  = 1'b1;
				cmd.link_wr_sel = LWR_VICTIM_FREE;
				cmd.give_victim = 1'b1;
				cmd.live_dec    = 1'b1;
				cmd.resp_en     = 1'b1;
				cmd.resp_status = ST_OK;
				state_d         = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/clrq_dp.sv
// ----------------------------------------------------------------------------
// clrq_dp
// Datapath: list pointers, counters, payload and link memories, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module clrq_dp #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire clrq_pkg::clrq_cmd_t  cmd,
	input  wire logic [1:0]           opcode,
	input  wire logic [63:0]          item_value,
	input  wire logic [7:0]           step_count,
	output clrq_pkg::clrq_stat_t      stat,
	output logic                      done,
	output logic [63:0]               out_value,
	output logic [6:0]                entry_count,
	output logic [1:0]                status
);

	import clrq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]            op_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [7:0]            steps_q;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         victim_q;
	logic [AW-1:0]         cursor_q;
	logic [AW-1:0]         free_q;
	logic [CW-1:0]         live_q;
	logic [CW-1:0]         fresh_q;
	logic [VALUE_BITS-1:0] result_q;
	logic                  done_q;
	logic [1:0]            status_q;

	logic [AW-1:0]         link_rdata;
	logic [AW-1:0]         link_raddr;
	logic [AW-1:0]         link_waddr;
	logic [AW-1:0]         link_wdata;
	logic [VALUE_BITS-1:0] pay_rdata;

	always_comb begin
		unique case (cmd.link_rd_sel)
			LRD_FREE:   link_raddr = free_q;
			LRD_CURSOR: link_raddr = cursor_q;
			LRD_RDATA:  link_raddr = link_rdata;
			default:    link_raddr = cursor_q;
		endcase
	end

	always_comb begin
		unique case (cmd.link_wr_sel)
			LWR_SELF: begin
				link_waddr = slot_q;
				link_wdata = slot_q;
			end
			LWR_SLOT_NEXT: begin
				link_waddr = slot_q;
				link_wdata = link_rdata;
			end
			LWR_CURSOR_SLOT: begin
				link_waddr = cursor_q;
				link_wdata = slot_q;
			end
			LWR_CURSOR_NEXT: begin
				link_waddr = cursor_q;
				link_wdata = link_rdata;
			end
			LWR_VICTIM_FREE: begin
				link_waddr = victim_q;
				link_wdata = free_q;
			end
			default: begin
				link_waddr = slot_q;
				link_wdata = slot_q;
			end
		endcase
	end

	clrq_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (cmd.link_wr_en),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.re   (cmd.link_rd_en),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	// payload read address is the victim slot straight off the link port
	clrq_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (cmd.pay_wr_en),
		.waddr(slot_q),
		.wdata(value_q),
		.re   (cmd.pay_rd_en),
		.raddr(link_rdata),
		.rdata(pay_rdata)
	);

	// request payload and scratch registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= opcode;
			value_q <= item_value[VALUE_BITS-1:0];
		end
		if (cmd.latch) begin
			steps_q <= step_count;
		end else if (cmd.steps_dec) begin
			steps_q <= steps_q - 8'd1;
		end
		if (cmd.take_free) begin
			slot_q <= free_q;
		end else if (cmd.take_fresh) begin
			slot_q <= fresh_q[AW-1:0];
		end
		if (cmd.victim_ld) begin
			victim_q <= link_rdata;
		end
		if (cmd.latch) begin
			result_q <= '0;
		end else if (cmd.result_ld) begin
			result_q <= pay_rdata;
		end
		if (cmd.resp_en) begin
			status_q <= cmd.resp_status;
		end
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			free_q   <= '0;
			live_q   <= '0;
			fresh_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.resp_en;
			if (cmd.cursor_to_slot) begin
				cursor_q <= slot_q;
			end else if (cmd.cursor_from_rd) begin
				cursor_q <= link_rdata;
			end
			if (cmd.free_from_rd) begin
				free_q <= link_rdata;
			end else if (cmd.give_victim) begin
				free_q <= victim_q;
			end
			if (cmd.live_inc) begin
				live_q <= live_q + CW'(1);
			end else if (cmd.live_dec) begin
				live_q <= live_q - CW'(1);
			end
			if (cmd.take_fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.full       = (live_q == CW'(DEPTH));
		stat.empty      = (live_q == '0);
		stat.reuse      = (fresh_q > live_q);
		stat.multi      = (live_q > CW'(1));
		stat.steps_zero = (steps_q == 8'd0);
		stat.steps_one  = (steps_q == 8'd1);
	end

	assign done        = done_q;
	assign out_value   = 64'(result_q);
	assign entry_count = 7'(live_q);
	assign status      = status_q;

endmodule

`default_nettype wire

// File: rtl/core/circular_list_rotate_queue_core.sv
// Length and empty/full rejects answer from the execute state; insert adds
// a free-chain fetch for a recycled slot and a splice after the cursor for
// a non-empty list; extract relinks and frees its victim; rotate steps the
// cursor. One request at a time; busy drops in the done cycle, so the next
// start can be taken while the result is shown. Done cannot be held.
// Reset (arst_n low) empties the list; both memories are left unwritten.
// ----------------------------------------------------------------------------
// circular_list_rotate_queue_core
// Circular linked list with a cursor on its last entry. Entries live in a
// payload RAM, next pointers in a link RAM; freed slots form a free chain.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_rotate_queue_core #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request side
	input  wire logic        start,
	input  wire logic [1:0]  opcode,
	input  wire logic [63:0] item_value,
	input  wire logic [7:0]  step_count,
	output logic             busy,
	// result side, one strobe per request
	output logic             done,
	output logic [63:0]      out_value,
	output logic [6:0]       entry_count,
	output logic [1:0]       status
);

	import clrq_pkg::*;

	// Controller sequences the memory accesses of each opcode; datapath holds
	// cursor, counts, free-chain head and the two RAMs. Rotate walks one link
	// per cycle through the single link memory read port.
	clrq_cmd_t  cmd;
	clrq_stat_t stat;

	clrq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.cmd   (cmd)
	);

	// A request is latched when start is seen in idle (cmd.latch). The
	// result fields are registered: entry_count tracks the live count, which
	// is already updated in the done cycle and cannot change before the next
	// request is accepted.
	clrq_dp #(
		.DEPTH     (DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.item_value (item_value),
		.step_count (step_count),
		.stat       (stat),
		.done       (done),
		.out_value  (out_value),
		.entry_count(entry_count),
		.status     (status)
	);

endmodule

`default_nettype wire

// File: rtl/core/clrq_checker.sv
// ----------------------------------------------------------------------------
// clrq_checker
// Port-level checks on request/result sequencing, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module clrq_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        done,
	input  wire logic [1:0]  status
);

	import clrq_pkg::*;

	`CLRQ_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "busy not raised after accept")
	`CLRQ_ASSERT(a_accept_no_done, clk, arst_n, (start && !busy) |=> !done, "result right after accept")
	`CLRQ_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	`CLRQ_ASSERT_IMPL(a_busy_end_done, clk, arst_n, $fell(busy), done, "request ended without result")
	`CLRQ_ASSERT_IMPL(a_status_code, clk, arst_n, done, status == ST_OK || status == ST_EMPTY || status == ST_FULL, "bad status code")

endmodule

bind circular_list_rotate_queue_core clrq_checker u_clrq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.status(status)
);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the circular list core request by request. A queue model of the
// list (front = entry after the cursor, back = cursor entry) predicts each
// result. Directed corner cases come first, then a fill and drain pass, then
// random mixes whose insert share changes from phase to phase.
// ----------------------------------------------------------------------------

module testbench;
	import clrq_pkg::*;

	localparam int DEPTH          = 64;
	localparam int VALUE_BITS     = 64;
	localparam int IDLE_LIMIT     = 2000; // cycles with no request and no result
	localparam int RANDOM_ITEMS   = 540;

	typedef struct packed {
		logic [63:0] value;
		logic [6:0]  count;
		logic [1:0]  status;
	} list_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request side, all driven from time zero
	logic        start      = 1'b0;
	logic [1:0]  opcode     = OP_LENGTH;
	logic [63:0] item_value = '0;
	logic [7:0]  step_count = '0;
	logic        busy;

	// result side
	logic        done;
	logic [63:0] out_value;
	logic [6:0]  entry_count;
	logic [1:0]  status;

	// model of the list: front is the oldest entry, back is the cursor entry
	logic [63:0]  list_model[$];
	// results predicted but not yet seen, oldest first
	list_result_t pending_results[$];
	int           mismatch_count = 0;

	// sender burst state
	int burst_left = 0;

	always #2 clk = ~clk;

	circular_list_rotate_queue_core #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.opcode(opcode),
		.item_value(item_value),
		.step_count(step_count),
		.busy(busy),
		.done(done),
		.out_value(out_value),
		.entry_count(entry_count),
		.status(status)
	);

	// Predicts one request and updates the list model.
	// Rotate moves the oldest entry behind the cursor once per step.
	function automatic list_result_t apply_list_op(input logic [1:0] op,
			input logic [63:0] val, input logic [7:0] steps);
		list_result_t r;
		int i;
		r.value  = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				if (list_model.size() >= DEPTH)
					r.status = ST_FULL;
				else
					list_model.push_back(val);
			end
			OP_ROTATE: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					for (i = 0; i < steps; i++)
						list_model.push_back(list_model.pop_front());
			end
			OP_EXTRACT: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					r.value = list_model.pop_front();
			end
			default: begin
			end
		endcase
		r.count = 7'(list_model.size());
		return r;
	endfunction

	// Random payload with a bias toward all-zero, all-one and checker words.
	function automatic logic [63:0] rand_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return {32{2'b01}};
			3:       return {32{2'b10}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Mostly short rotates, now and then a full-range one.
	function automatic logic [7:0] rand_steps();
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 8));
	endfunction

	// Sends one request and records its predicted result once accepted.
	// Requests go out in bursts; between bursts start drops for a random gap, which may be none.
	// Within a burst start stays high from one request to the next.
	task automatic issue_request(input logic [1:0] op, input logic [63:0] val,
			input logic [7:0] steps);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// long stretches with no gaps now and then
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(30, 90);
			else
				burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		start      <= 1'b1;
		opcode     <= op;
		item_value <= val;
		step_count <= steps;
		// busy read right after the edge is its value at the edge
		do @(posedge clk); while (busy);
		pending_results.push_back(apply_list_op(op, val, steps));
	endtask

	// Empty-list rejects, single-entry extract, extreme values and steps.
	task automatic test_directed();
		issue_request(OP_LENGTH,  '0, '0);
		issue_request(OP_EXTRACT, '1, '1);   // extract on empty list
		issue_request(OP_ROTATE,  '0, 8'd255); // rotate on empty list
		issue_request(OP_ROTATE,  '0, 8'd0);
		issue_request(OP_INSERT,  '0, '1);
		issue_request(OP_EXTRACT, '0, '0);   // only entry out: list empty
		issue_request(OP_EXTRACT, '0, '0);
		issue_request(OP_LENGTH,  '1, '1);
		issue_request(OP_INSERT,  '1, '0);   // recycled slot into empty list
		issue_request(OP_INSERT,  {32{2'b01}}, '0);
		issue_request(OP_INSERT,  {32{2'b10}}, '0);
		issue_request(OP_ROTATE,  '0, 8'd0);   // no movement
		issue_request(OP_ROTATE,  '0, 8'd1);
		issue_request(OP_ROTATE,  '0, 8'd255);
		issue_request(OP_LENGTH,  '0, '0);
		issue_request(OP_EXTRACT, '0, '0);
		issue_request(OP_INSERT,  64'h0123_4567_89ab_cdef, '0);
		issue_request(OP_ROTATE,  '0, 8'd2);
		issue_request(OP_EXTRACT, '0, '0);
		issue_request(OP_EXTRACT, '0, '0);
		issue_request(OP_EXTRACT, '0, '0);
		issue_request(OP_EXTRACT, '0, '0);   // drained again
	endtask

	// Fills the list past capacity, churns near full, then drains it.
	task automatic test_fill_drain();
		int i;
		for (i = 0; i < DEPTH + 3; i++)
			issue_request(OP_INSERT, rand_value(), rand_steps());
		issue_request(OP_LENGTH, '0, '0);
		issue_request(OP_ROTATE, '0, 8'($urandom_range(0, 255)));
		for (i = 0; i < 6; i++)
			issue_request(OP_EXTRACT, '0, '0);
		// freed slots come back off the free chain
		for (i = 0; i < 8; i++)
			issue_request(OP_INSERT, rand_value(), '0);
		issue_request(OP_ROTATE, '0, 8'd63);
		for (i = 0; i < DEPTH + 2; i++)
			issue_request(OP_EXTRACT, rand_value(), '0);
	endtask

	// Random phases; each phase picks how often it inserts, so the list
	// drifts between empty and full.
	task automatic test_random_mix();
		int sent;
		int phase_left;
		int insert_pct;
		int pick;
		logic [1:0] op;
		sent       = 0;
		phase_left = 0;
		insert_pct = 50;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0:       insert_pct = 80;
					1:       insert_pct = 20;
					default: insert_pct = 50;
				endcase
			end
			pick = $urandom_range(0, 99);
			if (pick < insert_pct)
				op = OP_INSERT;
			else begin
				pick = $urandom_range(0, 99);
				if (pick < 30)
					op = OP_ROTATE;
				else if (pick < 85)
					op = OP_EXTRACT;
				else
					op = OP_LENGTH;
			end
			issue_request(op, rand_value(), rand_steps());
			phase_left--;
			sent++;
		end
	endtask

	// Result checker: done is sampled at the edge that ends its cycle.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && done) begin
			got = '{value: out_value, count: entry_count, status: status};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected result: value %h count %0d status %0d",
					$time, got.value, got.count, got.status);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t mismatch: expected value %h count %0d status %0d, got value %h count %0d status %0d",
						$time, want.value, want.count, want.status,
						got.value, got.count, got.status);
				end
			end
		end
	end

	// Watchdog: any accepted request or result restarts the count.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain();
		test_random_mix();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// let any stray strobe show up
		repeat (16) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/clrq_pkg.sv
rtl/core/clrq_ram.sv
rtl/core/clrq_ctrl.sv
rtl/core/clrq_dp.sv
rtl/core/circular_list_rotate_queue_core.sv
rtl/core/clrq_checker.sv
test/testbench.sv
